FILE: sv/srrw_pkg.sv
// Shared types and constants of the selective-repeat receive window.
// Used by srrw_front, srrw_back and the top level; depends on nothing.
package srrw_pkg;

    localparam int SEQ_W      = 8;
    localparam int WORD_W     = 32;
    localparam int SPACE_W    = 9;
    localparam int WIN_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_SPACE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 1'b1;

    localparam logic [SPACE_W-1:0] SPACE_MIN   = 9'd2;
    localparam logic [SPACE_W-1:0] SPACE_MAX   = 9'd256;
    localparam logic [SPACE_W-1:0] SPACE_RESET = 9'd8;
    localparam logic [WIN_W-1:0]   WIN_RESET   = 4'd4;

    // Result kinds
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_num;
        logic [WORD_W-1:0] payload_word;
        logic              checksum_ok;
    } pkt_t;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  ack_number;
        logic [WORD_W-1:0] delivered_word;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [WORD_W-1:0] word;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } qhead_t;

    typedef struct packed {
        logic [SPACE_W-1:0] seq_space;
        logic [WIN_W-1:0]   win_len;
    } cfg_t;

endpackage

FILE: sv/selective_repeat_receive_window.sv
// Top level of the selective-repeat receive window: configuration registers,
// front and back parts. Depends on srrw_pkg, srrw_front and srrw_back.
// Usage:
//   pkt (valid/ready) carries one packet per transfer: seq_num, payload_word
//   and checksum_ok. res (valid/ready) carries results: an ack (kind 0) for
//   each good packet, then the payloads that became in-order (kind 1); last
//   marks the final result of a packet. Bad packets are taken and give nothing.
//   cfg_wr_en/cfg_index/cfg_wdata write the sequence space (index 0) and the
//   window length (index 1); write them only while the block is idle.
// Flow:
//   A good packet passes the queue, then its ack and each delivered payload
//   go out through the result register. The window unit takes the next
//   packet only once the results of the last are out. After seq_space shrinks
//   below the base, the next good packet waits while seq_space is subtracted
//   from the base. A two-entry queue sits between the front and the window
//   unit; pkt stays ready while results wait until both entries are taken.
// Reset:
//   Clears the valid marks, the base, the queue and the result valid flag and
//   loads a space of 8 and a window of 4. When res stalls, the window unit
//   holds and the queue fills; pkt ready drops once both entries are taken.
module selective_repeat_receive_window #(
    parameter int MAX_WINDOW   = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pkt_valid,
    output logic                                 pkt_ready,
    input  srrw_pkg::pkt_t                       pkt,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output srrw_pkg::res_t                       res,
    input  logic                                 cfg_wr_en,
    input  logic [srrw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srrw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import srrw_pkg::*;

    logic [SPACE_W-1:0] seq_space_reg;
    logic [WIN_W-1:0]   win_len_reg;
    cfg_t               cfg;
    qhead_t             q_head;
    logic               q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_space_reg <= SPACE_RESET;
            win_len_reg   <= WIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SEQ_SPACE: seq_space_reg <= cfg_wdata[SPACE_W-1:0];
                CFG_WIN_LEN:   win_len_reg   <= cfg_wdata[WIN_W-1:0];
                default:
                begin
                    seq_space_reg <= seq_space_reg;
                end
            endcase
        end
    end

    assign cfg.seq_space = seq_space_reg;
    assign cfg.win_len   = win_len_reg;

    srrw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    srrw_back #(
        .MAX_WINDOW   (MAX_WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

FILE: sv/srrw_front.sv
// Front part: accepts packets, drops those with a bad checksum and queues
// the good ones for the back part. Depends on srrw_pkg.
module srrw_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pkt_valid,
    output logic            pkt_ready,
    input  srrw_pkg::pkt_t  pkt,
    output srrw_pkg::qhead_t q_head,
    input  logic            q_pop
);
    import srrw_pkg::*;

    qent_t              q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               push;

    assign pkt_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    // bad packets are taken and vanish here
    assign push = pkt_valid && pkt_ready && pkt.checksum_ok;

    assign q_head.valid = (cnt_reg != '0);
    assign q_head.ent   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg].seq  <= pkt.seq_num;
            q_mem[wr_ptr_reg].word <= pkt.payload_word;
        end
    end

endmodule

FILE: sv/srrw_back.sv
// Back part: window check, slot buffer, ack and in-order delivery, and the
// result register. Takes queued packets from srrw_front; depends on srrw_pkg.
module srrw_back #(
    parameter int MAX_WINDOW   = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  srrw_pkg::cfg_t   cfg,
    input  srrw_pkg::qhead_t q_head,
    output logic             q_pop,
    output logic             res_valid,
    input  logic             res_ready,
    output srrw_pkg::res_t   res
);
    import srrw_pkg::*;

    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KEEP_W = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;
    localparam logic [SPACE_W-1:0] MAXW = SPACE_W'(MAX_WINDOW);

    localparam logic ST_PKT   = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                    state_reg, state_next;
    logic [SEQ_W-1:0]        base_reg, base_next;
    logic [MAX_WINDOW-1:0]   slot_valid_reg, slot_valid_next;
    logic [SEQ_W-1:0]        slot_seq_reg [MAX_WINDOW];
    logic [PAYLOAD_BITS-1:0] slot_pay_reg [MAX_WINDOW];
    logic                    out_valid_reg, out_valid_next;
    res_t                    out_reg, out_next;

    logic [SPACE_W-1:0]    m_eff, w_eff, base9, seq9, seq_off, next9;
    logic                  base_high, in_win, out_free, insert, ack_last;
    logic [MAX_WINDOW-1:0] hit_pkt, hit_base, hit_next;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic [WORD_W-1:0]     drain_word;

    always_comb
    begin
        if (cfg.seq_space < SPACE_MIN)
        begin
            m_eff = SPACE_MIN;
        end
        else if (cfg.seq_space > SPACE_MAX)
        begin
            m_eff = SPACE_MAX;
        end
        else
        begin
            m_eff = cfg.seq_space;
        end
        w_eff = SPACE_W'(cfg.win_len);
        if (w_eff > MAXW)
        begin
            w_eff = MAXW;
        end
        if (w_eff > m_eff)
        begin
            w_eff = m_eff;
        end
    end

    assign base9     = {1'b0, base_reg};
    assign seq9      = {1'b0, q_head.ent.seq};
    assign base_high = (base9 >= m_eff);
    assign seq_off   = (seq9 >= base9) ? (seq9 - base9) : (seq9 + m_eff - base9);
    assign in_win    = (seq9 < m_eff) && (seq_off < w_eff);
    assign next9     = (base9 + 1'b1 == m_eff) ? '0 : base9 + 1'b1;
    assign out_free  = !out_valid_reg || res_ready;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        drain_word = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            hit_pkt[i]  = slot_valid_reg[i] && (slot_seq_reg[i] == q_head.ent.seq);
            hit_base[i] = slot_valid_reg[i] && (slot_seq_reg[i] == base_reg);
            hit_next[i] = slot_valid_reg[i] && ({1'b0, slot_seq_reg[i]} == next9);
            if (hit_base[i])
            begin
                drain_word = drain_word | WORD_W'(slot_pay_reg[i][KEEP_W-1:0]);
            end
        end
        // lowest free slot wins
        for (int i = MAX_WINDOW - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign insert = (state_reg == ST_PKT) && q_head.valid && !base_high && out_free
                    && in_win && !(|hit_pkt) && free_found;
    assign ack_last = !((|hit_base) || (insert && (q_head.ent.seq == base_reg)));

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        slot_valid_next = slot_valid_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        case (state_reg)
            ST_PKT:
            begin
                if (q_head.valid)
                begin
                    if (base_high)
                    begin
                        // fold a stale base back into the space, one step a cycle
                        base_next = SEQ_W'(base9 - m_eff);
                    end
                    else if (out_free)
                    begin
                        q_pop                   = 1'b1;
                        out_valid_next          = 1'b1;
                        out_next.kind           = KIND_ACK;
                        out_next.ack_number     = q_head.ent.seq;
                        out_next.delivered_word = '0;
                        out_next.last           = ack_last;
                        if (insert)
                        begin
                            slot_valid_next[free_idx] = 1'b1;
                        end
                        if (!ack_last)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.kind           = KIND_DATA;
                    out_next.ack_number     = '0;
                    out_next.delivered_word = drain_word;
                    out_next.last           = !(|hit_next);
                    slot_valid_next         = slot_valid_reg & ~hit_base;
                    base_next               = SEQ_W'(next9);
                    if (!(|hit_next))
                    begin
                        state_next = ST_PKT;
                    end
                end
            end
            default:
            begin
                state_next = ST_PKT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_PKT;
            base_reg       <= '0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (insert)
        begin
            slot_seq_reg[free_idx] <= q_head.ent.seq;
            slot_pay_reg[free_idx] <= PAYLOAD_BITS'(q_head.ent.word[KEEP_W-1:0]);
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

`ifndef ASSERT_OFF
    a_drain_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> |hit_base)
        else $error("drain state without an entry at the base");

    a_seq_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_base) && $onehot0(hit_pkt))
        else $error("sequence number held in more than one slot");

    a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_ready && !out_reg.last |=> out_valid_reg)
        else $error("gap inside the results of one packet");
`endif

endmodule
